FILE: hdl/scaler_event_ring_queue_top_defines.svh
// ----------------------------------------------------------------------------
// scaler event ring queue assertion macros
// concurrent property wrappers shared by the checker
// ----------------------------------------------------------------------------
`ifndef SCALER_EVENT_RING_QUEUE_TOP_DEFINES_SVH
`define SCALER_EVENT_RING_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, reset masks the check
`define SERQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("serq assertion failed");

// next-cycle implication, reset masks the check
`define SERQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("serq assertion failed");

`endif

FILE: hdl/serq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serq_pkg
// shared types and constants of the scaler event ring queue
// ----------------------------------------------------------------------------
package serq_pkg;

    localparam int QUEUE_DEPTH  = 4096;
    localparam int POINTER_BITS = 16;
    localparam int LANES        = 4;
    localparam int LANE_BITS    = $clog2(LANES);
    localparam int SLOT_BITS    = $clog2(QUEUE_DEPTH);
    localparam int ROW_BITS     = SLOT_BITS - LANE_BITS;
    localparam int ROWS         = QUEUE_DEPTH / LANES;
    localparam int OVR_LIMIT    = QUEUE_DEPTH - 4;
    localparam int SKIP_OFFSET  = 16;
    localparam int COUNT_BITS   = 4;
    localparam int TIME_BITS    = 64;
    localparam int TIME_STEP_SH = 16;

    typedef enum logic
    {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_type_t;

    typedef struct packed
    {
        req_type_t   req_type;
        logic [31:0] scaler_word;
        logic [31:0] time_high;
    } req_t;

    typedef struct packed
    {
        logic                  event_valid;
        logic [COUNT_BITS-1:0] event_count;
        logic [TIME_BITS-1:0]  event_time;
        logic                  overrun;
    } evt_t;

    typedef struct packed
    {
        logic [COUNT_BITS-1:0] count;
        logic [TIME_BITS-1:0]  stamp;
    } lane_rd_t;

    // control handed from the pointer logic to the merge stage
    typedef struct packed
    {
        logic                 load;
        logic                 empty;
        logic                 overrun;
        logic [LANE_BITS-1:0] lane;
    } merge_ctl_t;

endpackage

FILE: hdl/scaler_event_ring_queue_top.sv
`timescale 1ns / 1ps
// push: all four entries written at once, no result
// pop: result is registered in the bank read, then in the lane merge
// throughput: one push per cycle; a pop is paced by the bank read and the
// result register: it waits while a read is in flight or a result is still held
// reset: pointers and enable cleared, no clearing pass; the store is undefined
// ----------------------------------------------------------------------------
// scaler_event_ring_queue_top
// ring queue of scaler events spread over four parallel banks
// ----------------------------------------------------------------------------
module scaler_event_ring_queue_top
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  serq_pkg::req_t req_data,
    output logic           evt_valid,
    input  logic           evt_stall,
    output serq_pkg::evt_t evt_data,
    input  logic           cfg_we,
    input  logic           cfg_wdata
);

    localparam int PB = serq_pkg::POINTER_BITS;

    // pointer and enable registers
    logic [PB-1:0]        wp_reg;
    logic [PB-1:0]        wp_next;
    logic [PB-1:0]        rp_reg;
    logic [PB-1:0]        rp_next;
    logic                 en_reg;
    logic                 en_next;
    serq_pkg::merge_ctl_t ctl_reg;
    serq_pkg::merge_ctl_t ctl_next;

    logic          accept;
    logic          push_acc;
    logic          pop_acc;
    logic          empty;
    logic [PB-1:0] diff;
    logic          skip;
    logic [PB-1:0] skip_ptr;
    logic [PB-1:0] eff_rp;

    serq_pkg::lane_rd_t lane_data [serq_pkg::LANES];

    // a pop waits while a read is in flight or a result is still held
    assign req_stall = (req_data.req_type == serq_pkg::REQ_POP) && (ctl_reg.load || evt_valid);
    assign accept    = req_valid && !req_stall;
    assign push_acc  = accept && (req_data.req_type == serq_pkg::REQ_PUSH) && en_reg;
    assign pop_acc   = accept && (req_data.req_type == serq_pkg::REQ_POP);

    // fill level and overrun skip, all modulo the pointer width
    assign empty    = (wp_reg == rp_reg);
    assign diff     = wp_reg - rp_reg;
    assign skip     = (diff > PB'(serq_pkg::OVR_LIMIT));
    assign skip_ptr = wp_reg - PB'(serq_pkg::QUEUE_DEPTH - serq_pkg::SKIP_OFFSET);
    assign eff_rp   = skip ? skip_ptr : rp_reg;

    always_comb
    begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        en_next = en_reg;
        if (push_acc)
        begin
            wp_next = wp_reg + PB'(serq_pkg::LANES);
        end
        if (pop_acc && !empty)
        begin
            rp_next = eff_rp + PB'(1);
        end
        // any enable write restarts the ring
        if (cfg_we)
        begin
            en_next = cfg_wdata;
            wp_next = '0;
            rp_next = '0;
        end
        ctl_next.load    = pop_acc;
        ctl_next.empty   = empty;
        ctl_next.overrun = skip && !empty;
        ctl_next.lane    = eff_rp[serq_pkg::LANE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            en_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            en_reg  <= en_next;
            ctl_reg <= ctl_next;
        end
    end

    // the write pointer only moves in steps of four, so a push fills one row
    // across all lanes; a pop reads the row in every lane and merges later
    for (genvar g = 0; g < serq_pkg::LANES; g++)
    begin : g_lane
        serq_lane u_lane
        (
            .clk      (clk),
            .lane_idx (serq_pkg::LANE_BITS'(g)),
            .wr_en    (push_acc),
            .wr_row   (wp_reg[serq_pkg::SLOT_BITS-1:serq_pkg::LANE_BITS]),
            .wr_word  (req_data.scaler_word),
            .wr_high  (req_data.time_high),
            .rd_en    (pop_acc),
            .rd_row   (eff_rp[serq_pkg::SLOT_BITS-1:serq_pkg::LANE_BITS]),
            .rd_data  (lane_data[g])
        );
    end

    serq_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_reg),
        .lane_data (lane_data),
        .evt_stall (evt_stall),
        .evt_valid (evt_valid),
        .evt_data  (evt_data)
    );

endmodule

FILE: hdl/serq_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serq_lane
// one bank of the ring: builds its entry of a push and serves registered reads
// ----------------------------------------------------------------------------
module serq_lane
(
    input  logic                           clk,
    input  logic [serq_pkg::LANE_BITS-1:0] lane_idx,
    input  logic                           wr_en,
    input  logic [serq_pkg::ROW_BITS-1:0]  wr_row,
    input  logic [31:0]                    wr_word,
    input  logic [31:0]                    wr_high,
    input  logic                           rd_en,
    input  logic [serq_pkg::ROW_BITS-1:0]  rd_row,
    output serq_pkg::lane_rd_t             rd_data
);

    logic [serq_pkg::COUNT_BITS-1:0] count_mem [serq_pkg::ROWS];
    logic [serq_pkg::TIME_BITS-1:0]  time_mem  [serq_pkg::ROWS];

    logic [serq_pkg::TIME_BITS-1:0]  base;
    logic [serq_pkg::TIME_BITS-1:0]  stamp;
    logic [serq_pkg::COUNT_BITS-1:0] nibble;

    // low half of the base is a constant with only the lsb set
    assign base   = {wr_high, wr_word[31:16], 16'h0001};
    assign stamp  = base + (64'(lane_idx) << serq_pkg::TIME_STEP_SH);
    assign nibble = wr_word[{lane_idx, 2'b00} +: serq_pkg::COUNT_BITS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            count_mem[wr_row] <= nibble;
            time_mem[wr_row]  <= stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data.count <= count_mem[rd_row];
            rd_data.stamp <= time_mem[rd_row];
        end
    end

endmodule

FILE: hdl/serq_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serq_merge
// picks the addressed lane and holds the result transaction
// ----------------------------------------------------------------------------
module serq_merge
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  serq_pkg::merge_ctl_t ctl,
    input  serq_pkg::lane_rd_t   lane_data [serq_pkg::LANES],
    input  logic                 evt_stall,
    output logic                 evt_valid,
    output serq_pkg::evt_t       evt_data
);

    logic           valid_reg;
    logic           valid_next;
    serq_pkg::evt_t data_reg;
    serq_pkg::evt_t data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (valid_reg && !evt_stall)
        begin
            valid_next = 1'b0;
        end
        if (ctl.load)
        begin
            valid_next = 1'b1;
            if (ctl.empty)
            begin
                data_next = '0;
            end
            else
            begin
                data_next.event_valid = 1'b1;
                data_next.event_count = lane_data[ctl.lane].count;
                data_next.event_time  = lane_data[ctl.lane].stamp;
                data_next.overrun     = ctl.overrun;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign evt_valid = valid_reg;
    assign evt_data  = data_reg;

endmodule

FILE: hdl/serq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serq_checker
// port-level properties of the scaler event ring queue
// ----------------------------------------------------------------------------
`include "scaler_event_ring_queue_top_defines.svh"

module serq_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input serq_pkg::req_t req_data,
    input logic           evt_valid,
    input logic           evt_stall,
    input serq_pkg::evt_t evt_data
);

    logic pop_acc;
    logic empty_res;
    logic empty_clean;

    assign pop_acc     = req_valid && !req_stall && (req_data.req_type == serq_pkg::REQ_POP);
    assign empty_res   = evt_valid && !evt_data.event_valid;
    assign empty_clean = (evt_data.event_count == '0) && (evt_data.event_time == '0)
                         && !evt_data.overrun;

    `SERQ_ASSERT_NEXT(a_evt_hold, clk, rst_n, evt_valid && evt_stall, evt_valid)
    `SERQ_ASSERT_IMPLY(a_pop_result, clk, rst_n, pop_acc, ##2 evt_valid)
    `SERQ_ASSERT_IMPLY(a_empty_zero, clk, rst_n, empty_res, empty_clean)
    `SERQ_ASSERT_IMPLY(a_pop_blocked, clk, rst_n, evt_valid && req_data.req_type, req_stall)

endmodule

bind scaler_event_ring_queue_top serq_checker u_serq_checker (.*);
